/* hdl/r2fft_pkg.sv */
// Shared constants, types and twiddle/address helpers for the radix-2 FFT core.
`default_nettype none
package r2fft_pkg;

    localparam int MaxLog2    = 6;
    localparam int MaxPoints  = 64;
    localparam int AddrW      = 6;
    localparam int CntW       = 7;
    localparam int SampleW    = 16;
    localparam int BinW       = 23;
    localparam int TwW        = 18;
    localparam int WordW      = 2 * BinW;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgLog2Points = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgInverse    = 2'd1;

    // one queued item: sample, frame slot and end-of-frame mark
    typedef struct packed {
        logic signed [SampleW-1:0] re;
        logic signed [SampleW-1:0] im;
        logic [CntW-1:0]           slot;
        logic                      last;
    } t_qentry;

    // clamp the length register into 1..MaxLog2
    function automatic logic [2:0] used_log2(input logic [2:0] lg);
        logic [2:0] r;
        if (lg == 3'd0) begin
            r = 3'd1;
        end else if (lg > 3'(MaxLog2)) begin
            r = 3'(MaxLog2);
        end else begin
            r = lg;
        end
        return r;
    endfunction

    // reverse the low lg bits of an index
    function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] i,
                                                 input logic [2:0] lg);
        logic [AddrW-1:0] r;
        for (int b = 0; b < AddrW; b++) begin
            r[AddrW-1-b] = i[b];
        end
        return r >> (3'(MaxLog2) - lg);
    endfunction

    // sin(2*pi*k/64) in Q1.16, first quarter
    function automatic logic signed [TwW-1:0] quarter_sine(input logic [4:0] idx);
        logic signed [TwW-1:0] v;
        case (idx)
            5'd0:  v = 18'sd0;
            5'd1:  v = 18'sd6424;
            5'd2:  v = 18'sd12785;
            5'd3:  v = 18'sd19024;
            5'd4:  v = 18'sd25080;
            5'd5:  v = 18'sd30893;
            5'd6:  v = 18'sd36410;
            5'd7:  v = 18'sd41576;
            5'd8:  v = 18'sd46341;
            5'd9:  v = 18'sd50660;
            5'd10: v = 18'sd54491;
            5'd11: v = 18'sd57798;
            5'd12: v = 18'sd60547;
            5'd13: v = 18'sd62714;
            5'd14: v = 18'sd64277;
            5'd15: v = 18'sd65220;
            5'd16: v = 18'sd65536;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TwW-1:0] tw_sin(input logic [AddrW-1:0] k);
        logic [4:0]            idx;
        logic signed [TwW-1:0] v;
        idx = k[4] ? (5'd16 - {1'b0, k[3:0]}) : {1'b0, k[3:0]};
        v   = quarter_sine(idx);
        return k[5] ? -v : v;
    endfunction

    function automatic logic signed [TwW-1:0] tw_cos(input logic [AddrW-1:0] k);
        return tw_sin(k + 6'd16);
    endfunction

endpackage
`default_nettype wire

/* hdl/r2fft_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module r2fft_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(Depth)-1:0] i_waddr,
    input  wire  [Width-1:0]         i_wdata,
    input  wire  [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hdl/r2fft_front.sv */
// Front end: accepts samples, tags frame slot and end of frame, queues them.
`default_nettype none
module r2fft_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  signed [r2fft_pkg::SampleW-1:0] i_sample_re,
    input  wire  signed [r2fft_pkg::SampleW-1:0] i_sample_im,
    input  wire  [2:0]                         i_log2,
    output logic                               o_q_valid,
    input  wire                                i_q_ready,
    output r2fft_pkg::t_qentry                 o_q_entry
);

    r2fft_pkg::t_qentry               r_fifo [r2fft_pkg::QueueDepth];
    logic [r2fft_pkg::QueuePtrW-1:0]  r_wptr, r_rptr;
    logic [r2fft_pkg::QueuePtrW:0]    r_count;
    logic [r2fft_pkg::CntW-1:0]       r_load_count;
    logic [r2fft_pkg::CntW:0]         npts;
    logic                             push, pop, frame_end;

    assign o_in_ready = (r_count != (r2fft_pkg::QueuePtrW + 1)'(r2fft_pkg::QueueDepth));
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_fifo[r_rptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;

    // frame ends when this sample brings the count up to the length in use
    assign npts      = (r2fft_pkg::CntW + 1)'(1) << r2fft_pkg::used_log2(i_log2);
    assign frame_end = ({1'b0, r_load_count} + 8'd1) >= npts;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= '{re: i_sample_re, im: i_sample_im,
                                slot: r_load_count, last: frame_end};
        end
    end

    // pointers and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_count      <= '0;
            r_load_count <= '0;
        end else begin
            if (push) begin
                r_wptr       <= r_wptr + 1'b1;
                r_load_count <= frame_end ? '0 : r_load_count + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/r2fft_back.sv */
// Back end: stores frames, bit-reverse copy, butterfly sequencer and bin unload.
`default_nettype none
module r2fft_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_q_valid,
    output logic                               o_q_ready,
    input  wire  r2fft_pkg::t_qentry           i_q_entry,
    input  wire  [2:0]                         i_log2,
    input  wire                                i_inverse,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [r2fft_pkg::BinW-1:0]  o_bin_re,
    output logic signed [r2fft_pkg::BinW-1:0]  o_bin_im,
    output logic                               o_last
);

    localparam int BW = r2fft_pkg::BinW;
    localparam int AW = r2fft_pkg::AddrW;
    localparam int CW = r2fft_pkg::CntW;
    localparam int PW = r2fft_pkg::TwW + BW;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_COPY   = 10'b0000000010,
        S_RDA    = 10'b0000000100,
        S_RDB    = 10'b0000001000,
        S_MUL    = 10'b0000010000,
        S_WRA    = 10'b0000100000,
        S_WRB    = 10'b0001000000,
        S_OUT_RD = 10'b0010000000,
        S_OUT_WR = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } t_state;

    t_state                          r_state, n_state;
    logic [2:0]                      r_lg, n_lg;
    logic                            r_inv, n_inv;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_pidx, n_pidx;
    logic [2:0]                      r_stage, n_stage;
    logic [AW-2:0]                   r_bf, n_bf;
    logic signed [BW-1:0]            r_a_re, r_a_im;
    logic signed [r2fft_pkg::TwW-1:0] r_wr, r_wi;
    logic signed [PW-1:0]            r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic                            r_ovld;
    logic signed [BW-1:0]            r_obre, r_obim;
    logic                            r_olast;

    logic                            a_we;
    logic [AW-1:0]                   a_raddr;
    logic [r2fft_pkg::WordW-1:0]     a_rdata, a_wdata;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr, w_raddr;
    logic [r2fft_pkg::WordW-1:0]     w_wdata, w_rdata;

    logic [CW-1:0]                   npts;
    logic [AW-1:0]                   half, mpart, grp, base, jdx, kidx;
    logic signed [BW-1:0]            b_re, b_im;
    logic signed [PW:0]              t_re_full, t_im_full;
    logic signed [PW-16:0]           t_re, t_im;
    logic signed [PW-16:0]           s_re, s_im, d_re, d_im;
    logic                            pop, out_load, out_last;

    assign npts      = CW'(1) << r_lg;
    assign o_q_ready = (r_state == S_LOAD);
    assign pop       = i_q_valid && o_q_ready;

    // sample store, written in arrival order
    assign a_we    = pop && !i_q_entry.slot[CW-1];
    assign a_wdata = {BW'(i_q_entry.re), BW'(i_q_entry.im)};
    assign a_raddr = r_cnt[AW-1:0];

    r2fft_ram #(.Width(r2fft_pkg::WordW), .Depth(r2fft_pkg::MaxPoints)) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (i_q_entry.slot[AW-1:0]),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    r2fft_ram #(.Width(r2fft_pkg::WordW), .Depth(r2fft_pkg::MaxPoints)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // butterfly addressing: pair (base, base+half), twiddle index m*64/len
    assign half  = AW'(1) << (r_stage - 3'd1);
    assign mpart = AW'(r_bf) & (half - 1'b1);
    assign grp   = AW'(r_bf) >> (r_stage - 3'd1);
    assign base  = (grp << r_stage) | mpart;
    assign jdx   = base | half;
    assign kidx  = mpart << (3'(r2fft_pkg::MaxLog2) - r_stage);

    // complex product rounding (floor of v/65536 + 1/2) and butterfly sums
    assign b_re      = w_rdata[2*BW-1:BW];
    assign b_im      = w_rdata[BW-1:0];
    assign t_re_full = (PW + 1)'(r_p_rr) - (PW + 1)'(r_p_ii) + (PW + 1)'(32768);
    assign t_im_full = (PW + 1)'(r_p_ri) + (PW + 1)'(r_p_ir) + (PW + 1)'(32768);
    assign t_re      = t_re_full[PW:16];
    assign t_im      = t_im_full[PW:16];
    assign s_re      = (PW - 15)'(r_a_re) + t_re;
    assign s_im      = (PW - 15)'(r_a_im) + t_im;
    assign d_re      = (PW - 15)'(r_a_re) - t_re;
    assign d_im      = (PW - 15)'(r_a_im) - t_im;

    assign out_load = (r_state == S_OUT_WR) && (!r_ovld || i_out_ready);
    assign out_last = (r_cnt + 1'b1) == npts;

    // work memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = base;
        w_wdata = {s_re[BW-1:0], s_im[BW-1:0]};
        w_raddr = base;
        unique case (r_state)
            S_COPY: begin
                w_we    = r_pend;
                w_waddr = r2fft_pkg::bit_rev(r_pidx, r_lg);
                w_wdata = a_rdata;
            end
            S_RDB: w_raddr = jdx;
            S_WRA: w_we = 1'b1;
            S_WRB: begin
                w_we    = 1'b1;
                w_waddr = jdx;
                w_wdata = {d_re[BW-1:0], d_im[BW-1:0]};
            end
            S_OUT_RD, S_OUT_WR: w_raddr = r_cnt[AW-1:0];
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_lg    = r_lg;
        n_inv   = r_inv;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_stage = r_stage;
        n_bf    = r_bf;
        unique case (r_state)
            S_LOAD: begin
                if (pop && i_q_entry.last) begin
                    n_lg    = r2fft_pkg::used_log2(i_log2);
                    n_inv   = i_inverse;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                n_pidx = r_cnt[AW-1:0];
                n_pend = (r_cnt != npts);
                if (r_cnt != npts) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_pend) begin
                    n_stage = 3'd1;
                    n_bf    = '0;
                    n_state = S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_MUL;
            S_MUL: n_state = S_WRA;
            S_WRA: n_state = S_WRB;
            S_WRB: begin
                if ((CW'(r_bf) + 1'b1) == (npts >> 1)) begin
                    n_bf = '0;
                    if (r_stage == r_lg) begin
                        n_cnt   = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_stage = r_stage + 1'b1;
                        n_state = S_RDA;
                    end
                end else begin
                    n_bf    = r_bf + 1'b1;
                    n_state = S_RDA;
                end
            end
            S_OUT_RD: n_state = S_OUT_WR;
            S_OUT_WR: begin
                if (out_load) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lg    <= 3'(r2fft_pkg::MaxLog2);
            r_inv   <= 1'b0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_stage <= 3'd1;
            r_bf    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lg    <= n_lg;
            r_inv   <= n_inv;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_stage <= n_stage;
            r_bf    <= n_bf;
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        if (r_state == S_RDA) begin
            r_wr <= r2fft_pkg::tw_cos(kidx);
            r_wi <= r_inv ? -r2fft_pkg::tw_sin(kidx) : r2fft_pkg::tw_sin(kidx);
        end
        if (r_state == S_RDB) begin
            r_a_re <= w_rdata[2*BW-1:BW];
            r_a_im <= w_rdata[BW-1:0];
        end
        if (r_state == S_MUL) begin
            r_p_rr <= PW'(r_wr) * PW'(b_re);
            r_p_ii <= PW'(r_wi) * PW'(b_im);
            r_p_ri <= PW'(r_wr) * PW'(b_im);
            r_p_ir <= PW'(r_wi) * PW'(b_re);
        end
        if (out_load) begin
            r_obre  <= w_rdata[2*BW-1:BW];
            r_obim  <= w_rdata[BW-1:0];
            r_olast <= out_last;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_bin_re    = r_obre;
    assign o_bin_im    = r_obim;
    assign o_last      = r_olast;

    // butterfly writes stay inside the frame
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRA || r_state == S_WRB) |-> (CW'(w_waddr) < npts))
        else $error("butterfly write outside frame");

    // the final bin hands the back end over to loading
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_last) |=> (r_state == S_LOAD))
        else $error("unload did not end after final bin");

    // stage counter stays within the transform length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDA) |-> (r_stage >= 3'd1 && r_stage <= r_lg))
        else $error("stage out of range");

endmodule
`default_nettype wire

/* hdl/radix2_complex_fft.sv */
// Holds no design unit; the core's top level is radix2_complex_fft_core.
`default_nettype none
`default_nettype wire

/* hdl/radix2_complex_fft_core.sv */
// Top level: configuration registers, front end queue and FFT back end.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready    i_sample_re, i_sample_im
//  out      output     o_out_valid / i_out_ready  o_bin_re, o_bin_im, o_last
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Samples enter at one per cycle into a 4-item queue while o_in_ready is high; the
// back end drains it while loading. A frame of N points then goes through a
// bit-reverse copy, butterflies on the single butterfly unit (read A, read B,
// multiply, write A, write B), and an unload of its bins that stalls with the output.
// Reset is synchronous, active low; sample memories are not cleared.
// A stalled output holds the last bin in its register while the next frame loads.
`default_nettype none
module radix2_complex_fft_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [r2fft_pkg::SampleW-1:0] i_sample_re,
    input  wire  signed [r2fft_pkg::SampleW-1:0] i_sample_im,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [r2fft_pkg::BinW-1:0]    o_bin_re,
    output logic signed [r2fft_pkg::BinW-1:0]    o_bin_im,
    output logic                                 o_last,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [r2fft_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  wire  [r2fft_pkg::CfgDataW-1:0]       i_cfg_data
);

    logic [2:0]         r_log2;
    logic               r_inverse;
    logic               q_valid, q_ready;
    r2fft_pkg::t_qentry q_entry;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2    <= 3'(r2fft_pkg::MaxLog2);
            r_inverse <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                r2fft_pkg::CfgLog2Points: r_log2    <= i_cfg_data;
                r2fft_pkg::CfgInverse:    r_inverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    r2fft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .i_log2      (r_log2),
        .o_q_valid   (q_valid),
        .i_q_ready   (q_ready),
        .o_q_entry   (q_entry)
    );

    r2fft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_entry   (q_entry),
        .i_log2      (r_log2),
        .i_inverse   (r_inverse),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_bin_re    (o_bin_re),
        .o_bin_im    (o_bin_im),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the radix-2 complex FFT core.
`default_nettype none

// Frame predictor and store of expected bins.
class fft_bin_board;
    logic signed [15:0] frame_re [64];
    logic signed [15:0] frame_im [64];
    int unsigned        fill;
    logic [2:0]         len_reg;
    logic               inv_reg;
    logic signed [22:0] exp_re [$];
    logic signed [22:0] exp_im [$];
    logic               exp_last [$];
    int                 errors;

    function new();
        fill    = 0;
        len_reg = 3'd6;
        inv_reg = 1'b0;
        errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [2:0] data);
        if (idx == r2fft_pkg::CfgLog2Points) len_reg = data;
        else if (idx == r2fft_pkg::CfgInverse) inv_reg = data[0];
    endfunction

    // Q1.16 sine of 2*pi*k/64
    function longint sine64(int unsigned k);
        longint q [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410, 41576, 46341,
                           50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};
        int unsigned qd;
        int unsigned r;
        qd = (k >> 4) & 3;
        r  = k & 15;
        case (qd)
            0: return q[r];
            1: return q[16 - r];
            2: return -q[r];
            default: return -q[16 - r];
        endcase
    endfunction

    // round to nearest, ties up
    function longint round16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function longint clip23(longint v);
        if (v > 4194303) return 4194303;
        if (v < -4194304) return -4194304;
        return v;
    endfunction

    // note one accepted sample; on frame end, compute the N bins
    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
        int unsigned lg;
        int unsigned n;
        int unsigned r;
        int unsigned half;
        int unsigned j;
        longint ar [64];
        longint ai [64];
        longint wr;
        longint wi;
        longint tr;
        longint ti;
        lg = (len_reg == 0) ? 1 : ((len_reg > 6) ? 6 : len_reg);
        n  = 1 << lg;
        if (fill < 64) begin
            frame_re[fill] = re;
            frame_im[fill] = im;
        end
        if (fill + 1 < n) begin
            fill++;
            return;
        end
        fill = 0;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int b = 0; b < lg; b++) if ((i >> b) & 1) r |= 1 << (lg - 1 - b);
            ar[r] = frame_re[i];
            ai[r] = frame_im[i];
        end
        for (int len = 2; len <= n; len <<= 1) begin
            half = len >> 1;
            for (int m = 0; m < half; m++) begin
                wr = sine64(((m * (64 / len)) + 16) & 63);
                wi = sine64((m * (64 / len)) & 63);
                if (inv_reg) wi = -wi;
                for (int bs = m; bs < n; bs += len) begin
                    j  = bs + half;
                    tr = round16(wr * ar[j] - wi * ai[j]);
                    ti = round16(wr * ai[j] + wi * ar[j]);
                    ar[j]  = ar[bs] - tr;
                    ai[j]  = ai[bs] - ti;
                    ar[bs] = ar[bs] + tr;
                    ai[bs] = ai[bs] + ti;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            exp_re.push_back(23'(clip23(ar[i])));
            exp_im.push_back(23'(clip23(ai[i])));
            exp_last.push_back(i == n - 1);
        end
    endfunction

    function void check_bin(logic signed [22:0] re, logic signed [22:0] im, logic lst);
        logic signed [22:0] er;
        logic signed [22:0] ei;
        logic               el;
        if (exp_re.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected bin re=%0d im=%0d last=%0b", re, im, lst);
            return;
        end
        er = exp_re.pop_front();
        ei = exp_im.pop_front();
        el = exp_last.pop_front();
        if (er !== re || ei !== im || el !== lst) begin
            errors++;
            if (errors <= 10)
                $display("bin mismatch: exp re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                         er, ei, el, re, im, lst);
        end
    endfunction

    function int pending();
        return exp_re.size();
    endfunction
endclass

module tb_top;
    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_ready;
    logic signed [r2fft_pkg::SampleW-1:0] i_sample_re = '0;
    logic signed [r2fft_pkg::SampleW-1:0] i_sample_im = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic signed [r2fft_pkg::BinW-1:0]    o_bin_re;
    logic signed [r2fft_pkg::BinW-1:0]    o_bin_im;
    logic                                 o_last;
    logic                                 i_cfg_valid = 1'b0;
    logic                                 o_cfg_ready;
    logic [r2fft_pkg::CfgIdxW-1:0]        i_cfg_index = '0;
    logic [r2fft_pkg::CfgDataW-1:0]       i_cfg_data = '0;

    fft_bin_board board = new();
    int  send_idle_pct = 15;
    int  recv_idle_pct = 54;
    int  hold_off = 0;
    longint cycle_count = 0;

    always #2 i_clk = ~i_clk;

    radix2_complex_fft_core i_dut (.*);

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("radix2_complex_fft_core: mismatch");
            $finish;
        end
    end

    // result sink: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_bin(o_bin_re, o_bin_im, o_last);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid drops only while idling or draining, so back-to-back items keep it high
    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(re, im);
    endtask

    // wait for all bins, then allow the back end to settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [r2fft_pkg::CfgIdxW-1:0] idx,
                             logic [r2fft_pkg::CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic rand_sample();
        logic signed [15:0] re;
        logic signed [15:0] im;
        case ($urandom_range(3))
            0: begin re = 16'sh7fff; im = 16'sh8000; end
            1: begin re = 16'sh8000; im = 16'sh7fff; end
            default: begin re = 16'($urandom); im = 16'($urandom); end
        endcase
        send_sample(re, im);
    endtask

    initial begin
        int sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at the shortest lengths, both directions
        write_reg(r2fft_pkg::CfgLog2Points, 3'd1);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd0); // zero acts as length two
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        drain();
        write_reg(r2fft_pkg::CfgInverse, 3'd1);
        write_reg(r2fft_pkg::CfgLog2Points, 3'd2);
        send_sample(16'sh0001, 16'sh0000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'shffff, 16'sh0001);
        // length shrunk during a load: the next sample ends the frame
        send_sample(16'sh1234, 16'sh4321);
        send_sample(16'sh8000, 16'sh0000);
        send_sample(16'sh7fff, 16'sh7fff);
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd1);
        send_sample(16'sh0100, 16'sh0200);
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd7); // above range acts as 64
        write_reg(r2fft_pkg::CfgInverse, 3'd0);

        // random phases over idling profiles and lengths
        sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : ((ph == 1) ? 54 : 0);
            recv_idle_pct = (ph == 0) ? 54 : ((ph == 1) ? 15 : 0);
            for (int f = 0; f < 4; f++) begin
                drain();
                // short frames under the long hold-off fill the queue and stall the input
                write_reg(r2fft_pkg::CfgLog2Points,
                          (f == 0 && ph == 0) ? 3'd6 :
                          ((f == 1) ? 3'd1 : 3'($urandom_range(1, 5))));
                write_reg(r2fft_pkg::CfgInverse, 3'($urandom_range(1)));
                if (f == 1) hold_off = 300;
                repeat ((f == 1) ? 12 : $urandom_range(4, 12)) begin
                    rand_sample();
                    sent++;
                end
                if (f == 2) drain();
            end
        end
        // finish any partial frame at length two, then full-size frame
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd0);
        rand_sample();
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd6);
        write_reg(r2fft_pkg::CfgInverse, 3'd1);
        while (sent < 420) begin
            if (sent % 64 == 0) begin
                drain();
                write_reg(r2fft_pkg::CfgLog2Points, 3'($urandom_range(1, 6)));
                write_reg(r2fft_pkg::CfgInverse, 3'($urandom_range(1)));
            end
            rand_sample();
            sent++;
        end
        drain();
        write_reg(r2fft_pkg::CfgLog2Points, 3'd1);
        rand_sample();
        drain();
        if (board.errors == 0) begin
            $display("radix2_complex_fft_core: match");
        end else begin
            $display("radix2_complex_fft_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* radix2_complex_fft_core.f */
hdl/r2fft_pkg.sv
hdl/r2fft_ram.sv
hdl/r2fft_front.sv
hdl/r2fft_back.sv
hdl/radix2_complex_fft.sv
hdl/radix2_complex_fft_core.sv
test/tb_top.sv
